@@ src/scq_pkg.sv @@
// scq_pkg: shared types, codes and helpers for the spi command queue sequencer
// no dependencies; imported by scq_poll_decode and spi_command_queue_sequencer
package scq_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QLEN_W      = 8;

   // one queue entry as stored in the ring memory
   typedef struct packed {
      logic [3:0]  kind;
      logic [15:0] len;
      logic [31:0] addr;
      logic [7:0]  reps;
      logic        free_req;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef enum logic [1:0] {
      REQ_ENQUEUE  = 2'd0,
      REQ_POLL     = 2'd1,
      REQ_TICK     = 2'd2,
      REQ_COMPLETE = 2'd3
   } req_code_type;

   localparam logic [3:0] KIND_DATA     = 4'd0;
   localparam logic [3:0] KIND_COMMAND  = 4'd1;
   localparam logic [3:0] KIND_PLAIN    = 4'd2;
   localparam logic [3:0] KIND_DELAY    = 4'd3;
   localparam logic [3:0] KIND_RESET    = 4'd4;
   localparam logic [3:0] KIND_UNRESET  = 4'd5;
   localparam logic [3:0] KIND_SELECT   = 4'd6;
   localparam logic [3:0] KIND_DESELECT = 4'd7;

   localparam logic [2:0] STAT_IDLE        = 3'd0;
   localparam logic [2:0] STAT_DELAYING    = 3'd1;
   localparam logic [2:0] STAT_DELAY_ENDED = 3'd2;
   localparam logic [2:0] STAT_BUSY        = 3'd3;
   localparam logic [2:0] STAT_INVALID     = 3'd4;
   localparam logic [2:0] STAT_DELAY_BEGUN = 3'd5;
   localparam logic [2:0] STAT_XFER_BEGUN  = 3'd6;
   localparam logic [2:0] STAT_PIN_SET     = 3'd7;

   // pin level bit positions
   localparam int PIN_DC    = 0;
   localparam int PIN_CS_N  = 1;
   localparam int PIN_RST_N = 2;

   localparam int          CSR_IDX_W         = 1;
   localparam logic [0:0]  CSR_USE_SELECT    = 1'd0;
   localparam logic [0:0]  CSR_USE_RESET_PIN = 1'd1;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } state_type;

   // what the head entry does when a poll takes it
   typedef struct packed {
      logic [2:0] status;
      logic       xfer;
      logic       delay;
      logic [2:0] pins;
   } poll_effect_type;

   function automatic logic [IDX_W-1:0] advance_idx(input logic [IDX_W-1:0] x);
      logic [IDX_W-1:0] nxt;
      nxt = (x == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : x + IDX_W'(1);
      return nxt;
   endfunction

endpackage

@@ src/scq_ram.sv @@
// scq_ram: generic single write port ram with registered read
// no dependencies
module scq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                      clock,
   input  logic                                      we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                          wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                          rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ src/scq_poll_decode.sv @@
// scq_poll_decode: works out what the head entry does when a poll takes it
// depends on scq_pkg
module scq_poll_decode
   import scq_pkg::*;
(
   input  entry_type       entry,
   input  logic [2:0]      pins,
   input  logic            use_select,
   input  logic            use_reset_pin,
   output poll_effect_type effect
);

   always_comb begin
      effect        = '0;
      effect.pins   = pins;
      effect.status = STAT_INVALID;
      unique case (entry.kind)
         KIND_DATA: begin
            effect.pins[PIN_DC] = 1'b1;
            effect.xfer         = 1'b1;
            effect.status       = STAT_XFER_BEGUN;
         end
         KIND_COMMAND: begin
            effect.pins[PIN_DC] = 1'b0;
            effect.xfer         = 1'b1;
            effect.status       = STAT_XFER_BEGUN;
         end
         KIND_PLAIN: begin
            effect.xfer   = 1'b1;
            effect.status = STAT_XFER_BEGUN;
         end
         KIND_DELAY: begin
            effect.delay  = 1'b1;
            effect.status = STAT_DELAY_BEGUN;
         end
         KIND_RESET: begin
            if (use_reset_pin) effect.pins[PIN_RST_N] = 1'b0;
            effect.status = STAT_PIN_SET;
         end
         KIND_UNRESET: begin
            if (use_reset_pin) effect.pins[PIN_RST_N] = 1'b1;
            effect.status = STAT_PIN_SET;
         end
         KIND_SELECT: begin
            if (use_select) effect.pins[PIN_CS_N] = 1'b0;
            effect.status = STAT_PIN_SET;
         end
         KIND_DESELECT: begin
            if (use_select) effect.pins[PIN_CS_N] = 1'b1;
            effect.status = STAT_PIN_SET;
         end
         default: begin
            effect.status = STAT_INVALID;
         end
      endcase
   end

endmodule

@@ src/spi_command_queue_sequencer.sv @@
// spi_command_queue_sequencer: top level, ring queue control around the entry ram
// depends on scq_pkg, scq_ram, scq_poll_decode
//
// usage
// a request word (enqueue, poll, tick or transfer complete) is taken when start is
// high and busy is low. every request gives exactly one response word, shown on
// the rsp_ ports for one cycle with rsp_valid high; it cannot be held off.
// timing: the head entry is read from the entry ram in the accept cycle, the
// next cycle executes the request (read-modify-write of the repeat count, or
// the enqueue write) and busy is high. the response appears in the cycle after
// that, while a new request may already be accepted. the execute state is there
// because the read of the entry ram is registered.
// the line levels rsp_dc_level, rsp_cs_n, rsp_reset_n and rsp_queue_length
// follow the block state and hold between responses.
// csr_we writes use_select (index 0) or use_reset_pin (index 1) at once; write
// only while idle.
// reset (synchronous) empties the queue, clears delay and transfer state, sets
// all lines high and both enables to 1. ram contents are not cleared; only
// entries between head and tail are ever used.
module spi_command_queue_sequencer
   import scq_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [1:0]           req_type,
   input  logic [3:0]           req_entry_type,
   input  logic [15:0]          req_length,
   input  logic [31:0]          req_address,
   input  logic [7:0]           req_repeats,
   input  logic                 req_should_free,
   output logic                 rsp_valid,
   output logic [2:0]           rsp_status,
   output logic                 rsp_enq_accepted,
   output logic                 rsp_xfer_start,
   output logic [31:0]          rsp_xfer_address,
   output logic [15:0]          rsp_xfer_length,
   output logic                 rsp_dc_level,
   output logic                 rsp_cs_n,
   output logic                 rsp_reset_n,
   output logic                 rsp_release_valid,
   output logic [31:0]          rsp_release_address,
   output logic [QLEN_W-1:0]    rsp_queue_length,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic                 csr_wdata
);

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] head_ff, head_in;
   logic [IDX_W-1:0] tail_ff, tail_in;
   logic             delaying_ff, delaying_in;
   logic [31:0]      delay_end_ff, delay_end_in;
   logic [31:0]      tick_now_ff, tick_now_in;
   logic             sending_ff, sending_in;
   logic             release_pending_ff, release_pending_in;
   logic [31:0]      cur_addr_ff, cur_addr_in;
   logic [2:0]       pins_ff, pins_in;
   logic             use_select_ff, use_reset_pin_ff;

   logic [1:0]       req_type_ff;
   entry_type        req_entry_ff;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [2:0]       rsp_status_ff, rsp_status_in;
   logic             rsp_enq_ff, rsp_enq_in;
   logic             rsp_xfer_ff, rsp_xfer_in;
   logic [31:0]      rsp_xfer_addr_ff, rsp_xfer_addr_in;
   logic [15:0]      rsp_xfer_len_ff, rsp_xfer_len_in;
   logic             rsp_rel_ff, rsp_rel_in;
   logic [31:0]      rsp_rel_addr_ff, rsp_rel_addr_in;

   logic             mem_we;
   logic [IDX_W-1:0] mem_waddr;
   entry_type        mem_wdata;
   logic [ENTRY_W-1:0] mem_rdata;
   entry_type        front_entry;
   poll_effect_type  effect;

   logic             accept;
   logic [IDX_W-1:0] tail_next;
   logic [IDX_W:0]   waiting;

   assign accept      = start && (state_ff == ST_IDLE);
   assign busy        = (state_ff != ST_IDLE);
   assign front_entry = entry_type'(mem_rdata);
   assign tail_next   = advance_idx(tail_ff);

   // head is read during the accept cycle so the entry is there for execution
   scq_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(QUEUE_DEPTH)
   ) u_entry_ram (
      .clock(clock),
      .we   (mem_we),
      .waddr(mem_waddr),
      .wdata(mem_wdata),
      .raddr(head_ff),
      .rdata(mem_rdata)
   );

   scq_poll_decode u_decode (
      .entry        (front_entry),
      .pins         (pins_ff),
      .use_select   (use_select_ff),
      .use_reset_pin(use_reset_pin_ff),
      .effect       (effect)
   );

   always_comb begin
      logic go;
      logic [2:0] idle_code;
      state_in           = state_ff;
      head_in            = head_ff;
      tail_in            = tail_ff;
      delaying_in        = delaying_ff;
      delay_end_in       = delay_end_ff;
      tick_now_in        = tick_now_ff;
      sending_in         = sending_ff;
      release_pending_in = release_pending_ff;
      cur_addr_in        = cur_addr_ff;
      pins_in            = pins_ff;
      rsp_valid_in       = 1'b0;
      rsp_status_in      = STAT_IDLE;
      rsp_enq_in         = 1'b0;
      rsp_xfer_in        = 1'b0;
      rsp_xfer_addr_in   = '0;
      rsp_xfer_len_in    = '0;
      rsp_rel_in         = 1'b0;
      rsp_rel_addr_in    = '0;
      mem_we             = 1'b0;
      mem_waddr          = tail_ff;
      mem_wdata          = req_entry_ff;
      go                 = 1'b1;
      idle_code          = STAT_IDLE;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in     = ST_IDLE;
            rsp_valid_in = 1'b1;
            unique case (req_type_ff)
               REQ_ENQUEUE: begin
                  if (tail_next != head_ff) begin
                     mem_we     = 1'b1;
                     tail_in    = tail_next;
                     rsp_enq_in = 1'b1;
                  end
               end
               REQ_POLL: begin
                  if (delaying_ff) begin
                     if (delay_end_ff != tick_now_ff) begin
                        rsp_status_in = STAT_DELAYING;
                        go            = 1'b0;
                     end else begin
                        delaying_in = 1'b0;
                        idle_code   = STAT_DELAY_ENDED;
                     end
                  end
                  if (go) begin
                     if (sending_ff) begin
                        rsp_status_in = STAT_BUSY;
                     end else if (head_ff == tail_ff) begin
                        rsp_status_in = idle_code;
                     end else begin
                        rsp_status_in = effect.status;
                        pins_in       = effect.pins;
                        if (effect.xfer) begin
                           sending_in         = 1'b1;
                           cur_addr_in        = front_entry.addr;
                           release_pending_in = (front_entry.reps == 8'd0) &&
                                                front_entry.free_req;
                           rsp_xfer_in        = 1'b1;
                           rsp_xfer_addr_in   = front_entry.addr;
                           rsp_xfer_len_in    = front_entry.len;
                        end
                        if (effect.delay) begin
                           delaying_in  = 1'b1;
                           delay_end_in = tick_now_ff + 32'(front_entry.len);
                        end
                        // repeating entry stays at the head with one pass fewer
                        if (front_entry.reps == 8'd0) begin
                           head_in = advance_idx(head_ff);
                        end else begin
                           mem_we         = 1'b1;
                           mem_waddr      = head_ff;
                           mem_wdata      = front_entry;
                           mem_wdata.reps = front_entry.reps - 8'd1;
                        end
                     end
                  end
               end
               REQ_TICK: begin
                  tick_now_in = tick_now_ff + 32'd1;
               end
               REQ_COMPLETE: begin
                  if (sending_ff) begin
                     rsp_rel_in         = release_pending_ff;
                     rsp_rel_addr_in    = release_pending_ff ? cur_addr_ff : '0;
                     release_pending_in = 1'b0;
                     sending_in         = 1'b0;
                  end
               end
               default: begin
                  rsp_status_in = STAT_IDLE;
               end
            endcase
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff           <= ST_IDLE;
         head_ff            <= '0;
         tail_ff            <= '0;
         delaying_ff        <= 1'b0;
         delay_end_ff       <= '0;
         tick_now_ff        <= '0;
         sending_ff         <= 1'b0;
         release_pending_ff <= 1'b0;
         cur_addr_ff        <= '0;
         pins_ff            <= 3'b111;
         use_select_ff      <= 1'b1;
         use_reset_pin_ff   <= 1'b1;
         rsp_valid_ff       <= 1'b0;
      end else begin
         state_ff           <= state_in;
         head_ff            <= head_in;
         tail_ff            <= tail_in;
         delaying_ff        <= delaying_in;
         delay_end_ff       <= delay_end_in;
         tick_now_ff        <= tick_now_in;
         sending_ff         <= sending_in;
         release_pending_ff <= release_pending_in;
         cur_addr_ff        <= cur_addr_in;
         pins_ff            <= pins_in;
         rsp_valid_ff       <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_USE_SELECT:    use_select_ff    <= csr_wdata;
               CSR_USE_RESET_PIN: use_reset_pin_ff <= csr_wdata;
               default: begin
                  use_select_ff <= use_select_ff;
               end
            endcase
         end
      end
   end

   // request word and response payload
   always_ff @(posedge clock) begin
      if (accept) begin
         req_type_ff           <= req_type;
         req_entry_ff.kind     <= req_entry_type;
         req_entry_ff.len      <= req_length;
         req_entry_ff.addr     <= req_address;
         req_entry_ff.reps     <= req_repeats;
         req_entry_ff.free_req <= req_should_free;
      end
      rsp_status_ff    <= rsp_status_in;
      rsp_enq_ff       <= rsp_enq_in;
      rsp_xfer_ff      <= rsp_xfer_in;
      rsp_xfer_addr_ff <= rsp_xfer_addr_in;
      rsp_xfer_len_ff  <= rsp_xfer_len_in;
      rsp_rel_ff       <= rsp_rel_in;
      rsp_rel_addr_ff  <= rsp_rel_addr_in;
   end

   assign waiting = (tail_ff >= head_ff)
                  ? {1'b0, tail_ff} - {1'b0, head_ff}
                  : {1'b0, tail_ff} + (IDX_W + 1)'(QUEUE_DEPTH) - {1'b0, head_ff};

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_enq_accepted    = rsp_enq_ff;
   assign rsp_xfer_start      = rsp_xfer_ff;
   assign rsp_xfer_address    = rsp_xfer_addr_ff;
   assign rsp_xfer_length     = rsp_xfer_len_ff;
   assign rsp_dc_level        = pins_ff[PIN_DC];
   assign rsp_cs_n            = pins_ff[PIN_CS_N];
   assign rsp_reset_n         = pins_ff[PIN_RST_N];
   assign rsp_release_valid   = rsp_rel_ff;
   assign rsp_release_address = rsp_rel_addr_ff;
   assign rsp_queue_length    = QLEN_W'(waiting);

   a_rsp_after_exec: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(state_ff == ST_EXEC))
      else $error("response word without an executed request");

   a_accept_to_exec: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_EXEC))
      else $error("accepted request did not execute");

   a_xfer_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_xfer_ff) |-> (rsp_status_ff == STAT_XFER_BEGUN))
      else $error("transfer started without transfer status");

   a_delay_xfer_excl: assert property (@(posedge clock) disable iff (reset)
      !(delaying_ff && sending_ff))
      else $error("delay and transfer active together");

   a_release_needs_send: assert property (@(posedge clock) disable iff (reset)
      release_pending_ff |-> sending_ff)
      else $error("release pending with no transfer running");

endmodule
